/* rtl/core/crm_pkg.sv */
`timescale 1ns / 1ps

package crm_pkg;

  // Widths of the fixed-point operands.
  localparam int unsigned PT_W   = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 2 * PT_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // The factor one half and the rounding to the point format: shift by 29.
  localparam int unsigned RES_SHIFT = 29;

  // One input transfer: position in the segment and four control values.
  typedef struct packed {
    logic        [15:0] frac;
    logic signed [31:0] point_a;
    logic signed [31:0] point_b;
    logic signed [31:0] point_c;
    logic signed [31:0] point_d;
  } crm_in_t;

  // One result transfer.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
  } crm_out_t;

  // Control values with their rounded Q.28 weights; element 0 is point_a.
  typedef struct packed {
    logic [3:0][PT_W-1:0] pt;
    logic [3:0][PT_W-1:0] wv;
    logic [3:0][PT_W-1:0] wd;
  } crm_wgt_t;

  // Pairwise sums of the weighted products; the low pairs carry the rounding term.
  typedef struct packed {
    logic signed [PAIR_W-1:0] sv_lo;
    logic signed [PAIR_W-1:0] sv_hi;
    logic signed [PAIR_W-1:0] sd_lo;
    logic signed [PAIR_W-1:0] sd_hi;
  } crm_sum_t;

endpackage

/* rtl/core/crm_basis.sv */
`timescale 1ns / 1ps

module crm_basis
  import crm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  crm_in_t  up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output crm_wgt_t dn_data
);

  localparam logic signed [37:0] ONE32   = 38'sh1_0000_0000;
  localparam logic signed [37:0] RND_D   = 38'sd8;
  localparam logic signed [52:0] ONE48   = 53'sh1_0000_0000_0000;
  localparam logic signed [52:0] RND_V   = 53'sd524288;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [FRAC_W-1:0]    s1_t_r;
  logic [31:0]          s1_t2_r;
  logic [3:0][PT_W-1:0] s1_pt_r;

  logic [FRAC_W-1:0]    s2_t_r;
  logic [31:0]          s2_t2_r;
  logic [47:0]          s2_t3_r;
  logic [3:0][PT_W-1:0] s2_pt_r;
  logic [3:0][PT_W-1:0] s2_wd_r;
  logic [3:0][PT_W-1:0] s2_wd_nxt;

  crm_wgt_t             s3_r;
  logic [3:0][PT_W-1:0] s3_wv_nxt;

  logic signed [37:0] d_t2, d_t1;
  logic signed [37:0] hd [4];
  logic signed [37:0] hd_rnd [4];
  logic signed [52:0] v_t3, v_t2, v_t1;
  logic signed [52:0] hv [4];
  logic signed [52:0] hv_rnd [4];

  // Each stage takes a new transfer when it is empty or its successor moves on.
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: square of the position.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_t_r  <= up_data.frac;
      s1_t2_r <= up_data.frac * up_data.frac;
      s1_pt_r <= {up_data.point_d, up_data.point_c, up_data.point_b, up_data.point_a};
    end
  end

  // Slope weights at scale 2^32, rounded half up to Q.28.
  always_comb begin
    d_t2  = {6'b0, s1_t2_r};
    d_t1  = {6'b0, s1_t_r, 16'b0};
    hd[0] = -(38'sd3 * d_t2) + (38'sd4 * d_t1) - ONE32;
    hd[1] = (38'sd9 * d_t2) - (38'sd10 * d_t1);
    hd[2] = -(38'sd9 * d_t2) + (38'sd8 * d_t1) + ONE32;
    hd[3] = (38'sd3 * d_t2) - (38'sd2 * d_t1);
    for (int i = 0; i < 4; i++) begin
      hd_rnd[i]    = (hd[i] + RND_D) >>> 4;
      s2_wd_nxt[i] = hd_rnd[i][PT_W-1:0];
    end
  end

  // Stage 2: cube of the position and the slope weights.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_t_r  <= s1_t_r;
      s2_t2_r <= s1_t2_r;
      s2_t3_r <= s1_t2_r * {16'b0, s1_t_r};
      s2_pt_r <= s1_pt_r;
      s2_wd_r <= s2_wd_nxt;
    end
  end

  // Value weights at scale 2^48, rounded half up to Q.28.
  always_comb begin
    v_t3  = {5'b0, s2_t3_r};
    v_t2  = {5'b0, s2_t2_r, 16'b0};
    v_t1  = {5'b0, s2_t_r, 32'b0};
    hv[0] = -v_t3 + (53'sd2 * v_t2) - v_t1;
    hv[1] = (53'sd3 * v_t3) - (53'sd5 * v_t2) + (53'sd2 * ONE48);
    hv[2] = -(53'sd3 * v_t3) + (53'sd4 * v_t2) + v_t1;
    hv[3] = v_t3 - v_t2;
    for (int i = 0; i < 4; i++) begin
      hv_rnd[i]    = (hv[i] + RND_V) >>> 20;
      s3_wv_nxt[i] = hv_rnd[i][PT_W-1:0];
    end
  end

  // Stage 3: all eight weights ready next to the control values.
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r.pt <= s2_pt_r;
      s3_r.wd <= s2_wd_r;
      s3_r.wv <= s3_wv_nxt;
    end
  end

endmodule

/* rtl/core/crm_mac.sv */
`timescale 1ns / 1ps

module crm_mac
  import crm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  crm_wgt_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output crm_sum_t dn_data
);

  localparam logic signed [PAIR_W-1:0] RND_HALF = PAIR_W'(1) << (RES_SHIFT - 1);

  logic v4_r, v5_r;
  logic rdy4, rdy5;

  logic signed [PROD_W-1:0] s4_pv_r [4];
  logic signed [PROD_W-1:0] s4_pd_r [4];
  crm_sum_t                 s5_r;

  assign rdy5     = !v5_r || dn_ready;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;
  assign dn_valid = v5_r;
  assign dn_data  = s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= up_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 4: eight signed 32 by 32 products.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 4; i++) begin
        s4_pv_r[i] <= $signed(up_data.pt[i]) * $signed(up_data.wv[i]);
        s4_pd_r[i] <= $signed(up_data.pt[i]) * $signed(up_data.wd[i]);
      end
    end
  end

  // Stage 5: pairwise sums, with the half LSB for rounding folded into the low pair.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_r.sv_lo <= PAIR_W'(s4_pv_r[0]) + PAIR_W'(s4_pv_r[1]) + RND_HALF;
      s5_r.sv_hi <= PAIR_W'(s4_pv_r[2]) + PAIR_W'(s4_pv_r[3]);
      s5_r.sd_lo <= PAIR_W'(s4_pd_r[0]) + PAIR_W'(s4_pd_r[1]) + RND_HALF;
      s5_r.sd_hi <= PAIR_W'(s4_pd_r[2]) + PAIR_W'(s4_pd_r[3]);
    end
  end

endmodule

/* rtl/core/crm_round.sv */
`timescale 1ns / 1ps

module crm_round
  import crm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  crm_sum_t up_data,
  output logic     dn_valid,
  input  logic     dn_stall,
  output crm_out_t dn_data
);

  localparam int unsigned SH_W = SUM_W - RES_SHIFT;

  logic     v6_r;
  logic     rdy6;
  crm_out_t s6_r;

  logic signed [SUM_W-1:0] sv_sum, sd_sum;
  logic signed [SH_W-1:0]  sv_sh, sd_sh;
  logic signed [PT_W-1:0]  value_nxt, slope_nxt;

  // Clamp a shifted sum to the signed 32-bit range.
  function automatic logic signed [PT_W-1:0] sat32(input logic signed [SH_W-1:0] x);
    logic [SH_W-PT_W:0] top;
    top = x[SH_W-1:PT_W-1];
    if (top == '0 || top == '1) begin
      return x[PT_W-1:0];
    end else if (x[SH_W-1]) begin
      return {1'b1, {(PT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(PT_W-1){1'b1}}};
    end
  endfunction

  assign rdy6     = !v6_r || !dn_stall;
  assign up_ready = rdy6;
  assign dn_valid = v6_r;
  assign dn_data  = s6_r;

  // Final sum, the halving shift with floor, and saturation.
  always_comb begin
    sv_sum    = SUM_W'(up_data.sv_lo) + SUM_W'(up_data.sv_hi);
    sd_sum    = SUM_W'(up_data.sd_lo) + SUM_W'(up_data.sd_hi);
    sv_sh     = SH_W'(sv_sum >>> RES_SHIFT);
    sd_sh     = SH_W'(sd_sum >>> RES_SHIFT);
    value_nxt = sat32(sv_sh);
    slope_nxt = sat32(sd_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= up_valid;
    end
  end

  // Stage 6: output register, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_r.value <= value_nxt;
      s6_r.slope <= slope_nxt;
    end
  end

endmodule

/* rtl/core/catmull_rom_interpolator.sv */
`timescale 1ns / 1ps

// Uniform Catmull-Rom segment evaluator.
// The input channel (in_valid, in_stall, in_data) carries a Q0.16 position and
// the four control values around the segment; the output channel (out_valid,
// out_stall, out_data) returns the interpolated value and the slope, both in
// the control values' signed fixed-point format and saturated to 32 bits.
// A transfer happens on a rising edge with valid high and stall low.
// The pipeline has six register stages: square, cube and slope weights, value
// weights, products, pairwise sums, final sum with rounding and saturation.
// Throughput is one item per cycle while nothing stalls, set by the multipliers
// of stages one, two and four, each of which takes a new operand set every
// cycle.
// While the receiver stalls, the result stays on out_data and empty stages
// keep filling; in_stall rises only once all six stages hold items.
// Synchronous reset (rst_n low) empties the pipeline; no item is kept.

module catmull_rom_interpolator
  import crm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  crm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output crm_out_t out_data
);

  logic     bas_ready;
  logic     wgt_valid, wgt_ready;
  crm_wgt_t wgt_data;
  logic     sum_valid, sum_ready;
  crm_sum_t sum_data;

  assign in_stall = !bas_ready;

  // Basis weights from the position.
  crm_basis u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (bas_ready),
    .up_data  (in_data),
    .dn_valid (wgt_valid),
    .dn_ready (wgt_ready),
    .dn_data  (wgt_data)
  );

  // Weighted products and partial sums.
  crm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (wgt_valid),
    .up_ready (wgt_ready),
    .up_data  (wgt_data),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  // Final sum, rounding, saturation and output register.
  crm_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

/* rtl/core/crm_checker.sv */
`timescale 1ns / 1ps

module crm_checker
  import crm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input crm_out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The input only stalls when the pipeline is full behind a stalled result.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind catmull_rom_interpolator crm_checker u_crm_checker (.*);
